@@ rtl/otb_pkg.sv @@
// otb_pkg: shared types, constants and helpers of the one-shot timer bank
// used by otb_seq, one_shot_timer_bank_unit, otb_checker and tb; depends on nothing
package otb_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int COUNT_WIDTH = 32;

  localparam int CMD_W      = 3;
  localparam int SLOT_OUT_W = 4;
  localparam int DUR_W      = 32;
  localparam int REM_W      = 32;

  // slot index and scan counter widths
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = SLOT_W + 1;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLAIM   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SLOT_W-1:0]      slot_idx_t;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [SLOT_OUT_W-1:0] slot_id;
    logic [DUR_W-1:0]      duration_ms;
  } in_item_t;

  typedef struct packed {
    logic                  kind;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic                  ok;
    logic [REM_W-1:0]      left_ticks;
    logic                  last;
  } out_item_t;

  // one result handed from the sequencer to the output register
  typedef struct packed {
    logic      vld;
    out_item_t res;
  } push_t;

  // count memory request
  typedef struct packed {
    logic      we;
    slot_idx_t waddr;
    count_t    wdata;
    logic      re;
    slot_idx_t raddr;
  } ram_req_t;

  // clamp a requested duration to the count width
  function automatic count_t sat_count(logic [DUR_W-1:0] d);
    logic [63:0] wide;
    wide = 64'(d);
    if (COUNT_WIDTH >= DUR_W) begin
      return COUNT_WIDTH'(d);
    end else if (wide > 64'(COUNT_MAX)) begin
      return COUNT_MAX;
    end else begin
      return COUNT_WIDTH'(d);
    end
  endfunction

  function automatic logic [SLOT_OUT_W-1:0] to_slot_out(slot_idx_t s);
    return SLOT_OUT_W'(s);
  endfunction

  function automatic slot_idx_t to_slot_idx(logic [SLOT_OUT_W-1:0] s);
    return SLOT_W'(s);
  endfunction

  function automatic logic [REM_W-1:0] to_rem(count_t c);
    return REM_W'(c);
  endfunction

endpackage

@@ rtl/otb_ram.sv @@
// otb_ram: generic one-write one-read memory with registered read data
// standalone, no package dependency
module otb_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/otb_seq.sv @@
// otb_seq: command sequencer and tick scanner of the one-shot timer bank
// depends on otb_pkg; drives the count memory and the output register
module otb_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  otb_pkg::in_item_t in_data_i,
  output logic              in_stall_o,
  input  logic              push_ok_i,
  output otb_pkg::push_t    push_o,
  output otb_pkg::ram_req_t ram_o,
  input  otb_pkg::count_t   ram_rdata_i
);

  localparam int SlotW = otb_pkg::SLOT_W;
  localparam int CntW  = otb_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMD  = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;

  logic [1:0]                     state_q, state_d;
  otb_pkg::in_item_t              req_q, req_d;
  logic [otb_pkg::NUM_SLOTS-1:0]  act_q, act_d;
  logic [otb_pkg::NUM_SLOTS-1:0]  use_q, use_d;
  logic [CntW-1:0]                rd_idx_q, rd_idx_d;
  logic                           s2_vld_q, s2_vld_d;
  logic [SlotW-1:0]               s2_idx_q, s2_idx_d;
  logic                           pend_vld_q, pend_vld_d;
  logic [SlotW-1:0]               pend_idx_q, pend_idx_d;

  logic [SlotW-1:0] sidx;
  logic             sid_ok;
  otb_pkg::count_t  cnt_nxt;
  logic             expire;
  logic             scan_stall;
  logic             scan_done;

  assign in_stall_o = (state_q != ST_IDLE);
  assign sidx       = otb_pkg::to_slot_idx(req_q.slot_id);
  assign sid_ok     = (int'(req_q.slot_id) < otb_pkg::NUM_SLOTS);
  assign cnt_nxt    = (ram_rdata_i == '0) ? '0 :
                      otb_pkg::COUNT_WIDTH'(ram_rdata_i - otb_pkg::COUNT_WIDTH'(1));
  assign expire     = s2_vld_q && act_q[s2_idx_q] && (cnt_nxt == '0);
  assign scan_stall = expire && pend_vld_q && !push_ok_i;
  assign scan_done  = (rd_idx_q == CntW'(otb_pkg::NUM_SLOTS)) && !s2_vld_q;

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    act_d      = act_q;
    use_d      = use_q;
    rd_idx_d   = rd_idx_q;
    s2_vld_d   = s2_vld_q;
    s2_idx_d   = s2_idx_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    push_o     = '0;
    ram_o      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d       = in_data_i;
          ram_o.re    = 1'b1;
          ram_o.raddr = otb_pkg::to_slot_idx(in_data_i.slot_id);
          if (in_data_i.cmd == otb_pkg::CMD_TICK) begin
            state_d    = ST_TICK;
            rd_idx_d   = '0;
            s2_vld_d   = 1'b0;
            pend_vld_d = 1'b0;
          end else begin
            state_d = ST_CMD;
          end
        end
      end

      ST_CMD: begin
        if (push_ok_i) begin
          push_o.vld            = 1'b1;
          push_o.res.kind       = otb_pkg::KIND_ACK;
          push_o.res.slot_out   = req_q.slot_id;
          push_o.res.ok         = 1'b0;
          push_o.res.left_ticks = '0;
          push_o.res.last       = 1'b1;
          if (sid_ok) begin
            unique case (req_q.cmd)
              otb_pkg::CMD_START: begin
                if (req_q.duration_ms == '0) begin
                  act_d[sidx]   = 1'b0;
                  push_o.res.ok = 1'b1;
                end else if (use_q[sidx]) begin
                  ram_o.we      = 1'b1;
                  ram_o.waddr   = sidx;
                  ram_o.wdata   = otb_pkg::sat_count(req_q.duration_ms);
                  act_d[sidx]   = 1'b1;
                  push_o.res.ok = 1'b1;
                end
              end
              otb_pkg::CMD_QUERY: begin
                push_o.res.ok = 1'b1;
                if (act_q[sidx]) begin
                  push_o.res.left_ticks = otb_pkg::to_rem(ram_rdata_i);
                end
              end
              otb_pkg::CMD_CLAIM: begin
                if (!use_q[sidx]) begin
                  use_d[sidx]   = 1'b1;
                  act_d[sidx]   = 1'b0;
                  push_o.res.ok = 1'b1;
                end
              end
              otb_pkg::CMD_RELEASE: begin
                if (use_q[sidx]) begin
                  use_d[sidx]   = 1'b0;
                  act_d[sidx]   = 1'b0;
                  push_o.res.ok = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
          state_d = ST_IDLE;
        end
      end

      ST_TICK: begin
        if (scan_done) begin
          // flush the held expiry as the last result
          if (pend_vld_q) begin
            if (push_ok_i) begin
              push_o.vld            = 1'b1;
              push_o.res.kind       = otb_pkg::KIND_EXPIRY;
              push_o.res.slot_out   = otb_pkg::to_slot_out(pend_idx_q);
              push_o.res.ok         = 1'b1;
              push_o.res.left_ticks = '0;
              push_o.res.last       = 1'b1;
              pend_vld_d            = 1'b0;
              state_d               = ST_IDLE;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end else if (!scan_stall) begin
          if (rd_idx_q < CntW'(otb_pkg::NUM_SLOTS)) begin
            ram_o.re    = 1'b1;
            ram_o.raddr = rd_idx_q[SlotW-1:0];
            rd_idx_d    = CntW'(rd_idx_q + CntW'(1));
            s2_vld_d    = 1'b1;
            s2_idx_d    = rd_idx_q[SlotW-1:0];
          end else begin
            s2_vld_d = 1'b0;
          end
          if (s2_vld_q && act_q[s2_idx_q]) begin
            ram_o.we    = 1'b1;
            ram_o.waddr = s2_idx_q;
            ram_o.wdata = cnt_nxt;
            if (expire) begin
              act_d[s2_idx_q] = 1'b0;
              if (pend_vld_q) begin
                push_o.vld            = 1'b1;
                push_o.res.kind       = otb_pkg::KIND_EXPIRY;
                push_o.res.slot_out   = otb_pkg::to_slot_out(pend_idx_q);
                push_o.res.ok         = 1'b1;
                push_o.res.left_ticks = '0;
                push_o.res.last       = 1'b0;
              end
              pend_vld_d = 1'b1;
              pend_idx_d = s2_idx_q;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      act_q      <= '0;
      use_q      <= '0;
      rd_idx_q   <= '0;
      s2_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      act_q      <= act_d;
      use_q      <= use_d;
      rd_idx_q   <= rd_idx_d;
      s2_vld_q   <= s2_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    s2_idx_q   <= s2_idx_d;
    pend_idx_q <= pend_idx_d;
  end

endmodule

@@ rtl/one_shot_timer_bank_unit.sv @@
// one_shot_timer_bank_unit: top level of the one-shot timer bank
// depends on otb_pkg, otb_ram and otb_seq
//
//   channel  direction  payload              handshake
//   in       input      otb_pkg::in_item_t   in_valid_i / in_stall_o
//   out      output     otb_pkg::out_item_t  out_valid_o / out_stall_i
//
// a non-tick request is accepted together with its count read, then its ack is pushed
// a tick request is accepted, then the scan reads each slot from the count
// memory, writes back each active count and flushes any held expiry last
// reset clears the active and in-use flags; the count memory is not cleared
// since a count is only used for an active slot, which was always loaded
// a stalled output holds the result register; the sequencer waits to push
module one_shot_timer_bank_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  otb_pkg::in_item_t  in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output otb_pkg::out_item_t out_data_o,
  input  logic               out_stall_i
);

  otb_pkg::push_t     push;
  otb_pkg::ram_req_t  ram_req;
  otb_pkg::count_t    ram_rdata;
  logic               push_ok;
  logic               out_valid_q, out_valid_d;
  otb_pkg::out_item_t out_q;

  // sequencer: decodes requests, scans slots on a tick, owns the flags
  otb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .push_ok_i   (push_ok),
    .push_o      (push),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // remaining count per slot
  otb_ram #(
    .DEPTH (otb_pkg::NUM_SLOTS),
    .WIDTH (otb_pkg::COUNT_WIDTH)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // output register: takes a new result when empty or being drained
  assign push_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (push.vld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.vld) begin
      out_q <= push.res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // the sequencer never overwrites a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni) push.vld |-> push_ok)
    else $error("result pushed into a full output register");

  // an accepted request keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block idle right after accepting a request");

  // a count write always comes from a busy block
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_req.we |-> in_stall_o)
    else $error("count memory written while idle");
`endif

endmodule

@@ sim/otb_checker.sv @@
// otb_checker: watches both channels of the one-shot timer bank, keeps its own
// copy of the slot counts and flags, and checks every result in order
// depends on otb_pkg
module otb_checker
  import otb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_data_i,
  input  logic      in_stall_i,
  input  logic      out_valid_i,
  input  out_item_t out_data_i,
  input  logic      out_stall_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  count_t    slot_count   [NUM_SLOTS];
  logic      slot_running [NUM_SLOTS];
  logic      slot_claimed [NUM_SLOTS];
  out_item_t expected_results [$];

  // apply one request to the slot state and queue the results it causes
  task automatic predict_request(input in_item_t req);
    out_item_t ack;
    out_item_t expiry;
    int        fired [NUM_SLOTS];
    int        n_fired;
    int        s;
    count_t    load;
    ack = '{kind: KIND_ACK, slot_out: req.slot_id, ok: 1'b0, left_ticks: '0, last: 1'b1};
    n_fired = 0;
    s = int'(req.slot_id);
    if (req.cmd == CMD_TICK) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_running[i]) begin
          if (slot_count[i] != '0) slot_count[i] = slot_count[i] - 1'b1;
          if (slot_count[i] == '0) begin
            slot_running[i] = 1'b0;
            fired[n_fired] = i;
            n_fired++;
          end
        end
      end
      for (int k = 0; k < n_fired; k++) begin
        expiry = '{kind: KIND_EXPIRY, slot_out: SLOT_OUT_W'(fired[k]), ok: 1'b1,
                   left_ticks: '0, last: (k == n_fired - 1)};
        expected_results.push_back(expiry);
      end
    end else if (req.cmd > CMD_RELEASE || s >= NUM_SLOTS) begin
      expected_results.push_back(ack);
    end else begin
      case (req.cmd)
        CMD_START: begin
          if (req.duration_ms == '0) begin
            slot_running[s] = 1'b0;
            slot_count[s]   = '0;
            ack.ok = 1'b1;
          end else if (slot_claimed[s]) begin
            // clamp to the widest count the bank holds
            load = (64'(req.duration_ms) > 64'(COUNT_MAX)) ? COUNT_MAX
                                                            : COUNT_WIDTH'(req.duration_ms);
            slot_count[s]   = load;
            slot_running[s] = 1'b1;
            ack.ok = 1'b1;
          end
        end
        CMD_QUERY: begin
          ack.left_ticks = slot_running[s] ? REM_W'(slot_count[s]) : '0;
          ack.ok = 1'b1;
        end
        CMD_CLAIM: begin
          if (!slot_claimed[s]) begin
            slot_claimed[s] = 1'b1;
            slot_running[s] = 1'b0;
            slot_count[s]   = '0;
            ack.ok = 1'b1;
          end
        end
        default: begin
          if (slot_claimed[s]) begin
            slot_claimed[s] = 1'b0;
            slot_running[s] = 1'b0;
            slot_count[s]   = '0;
            ack.ok = 1'b1;
          end
        end
      endcase
      expected_results.push_back(ack);
    end
  endtask

  task automatic flag_field(input string field, input logic [REM_W-1:0] want,
                            input logic [REM_W-1:0] got);
    fail_count_o++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      fail_count_o++;
      $display("%0t: result with nothing expected, expected none, actual %p", $time, got);
    end else begin
      want = expected_results.pop_front();
      if (got.kind !== want.kind)
        flag_field("kind", REM_W'(want.kind), REM_W'(got.kind));
      if (got.slot_out !== want.slot_out)
        flag_field("slot_out", REM_W'(want.slot_out), REM_W'(got.slot_out));
      if (got.ok !== want.ok)
        flag_field("ok", REM_W'(want.ok), REM_W'(got.ok));
      if (got.left_ticks !== want.left_ticks)
        flag_field("left_ticks", want.left_ticks, got.left_ticks);
      if (got.last !== want.last)
        flag_field("last", REM_W'(want.last), REM_W'(got.last));
    end
  endtask

  // results go first: one leaving at this edge can't come from a request taken now
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_count[i]   = '0;
        slot_running[i] = 1'b0;
        slot_claimed[i] = 1'b0;
      end
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) predict_request(in_data_i);
      pending_o = expected_results.size();
    end
  end

endmodule

@@ sim/tb.sv @@
// tb: drives timer-bank requests with random gaps and back-pressure, and
// reports the verdict; depends on otb_pkg, otb_checker and the timer bank rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import otb_pkg::*;

  // codes past release are not commands; the bank must refuse them
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_RELEASE + 1'b1;
  localparam logic [CMD_W-1:0] CMD_LAST_CODE    = '1;

  localparam int RANDOM_ITEMS = 320;
  // worst case per request: long gap, a full tick pass, 16 expiries each
  // behind a long stall; the limit is several times that over the whole run
  localparam int CYCLE_LIMIT  = 1_000_000;
  // a tick pass plus a long stall, so a stray result still shows up
  localparam int DRAIN_CYCLES = 4 * NUM_SLOTS + 64;

  typedef logic [SLOT_OUT_W-1:0] slot_field_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  in_item_t  in_data_i;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;
  logic      out_stall_i;

  int failures;
  int pending;
  int sent;
  int cycles;
  // when set, neither side idles: back-to-back requests, no back-pressure
  logic calm;

  one_shot_timer_bank_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  otb_checker timer_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_i   (in_stall_o),
    .out_valid_i  (out_valid_o),
    .out_data_i   (out_data_o),
    .out_stall_i  (out_stall_i),
    .fail_count_o (failures),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // idle stretch length: mostly none or short, now and then long
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // timer length: mostly a few ticks so slots expire, sometimes a stop,
  // a full-range value or the largest count
  function automatic logic [DUR_W-1:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return DUR_W'($urandom());
    if (r == 2) return DUR_W'(COUNT_MAX);
    return DUR_W'($urandom_range(1, 6));
  endfunction

  function automatic slot_field_t any_slot();
    return slot_field_t'($urandom_range(0, NUM_SLOTS - 1));
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [CMD_W-1:0] cmd, input slot_field_t slot,
                              input logic [DUR_W-1:0] dur);
    int unsigned gap;
    gap = calm ? 0 : pick_idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{cmd: cmd, slot_id: slot, duration_ms: dur};
    // payload holds while the bank stalls
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent++;
  endtask

  // well-formed use: claim a run of slots, arm them, tick them down with
  // queries mixed in, then free some of them
  task automatic run_timer_burst();
    int unsigned n_slots;
    int unsigned base;
    logic [DUR_W-1:0] shared_dur;
    slot_field_t s;
    // an all-slot burst with mostly one short length makes many slots expire together
    n_slots = ($urandom_range(0, 6) == 0) ? NUM_SLOTS : $urandom_range(1, 4);
    base = $urandom_range(0, NUM_SLOTS - 1);
    shared_dur = DUR_W'($urandom_range(1, 3));
    for (int i = 0; i < n_slots; i++) begin
      s = slot_field_t'((base + i) % NUM_SLOTS);
      if ($urandom_range(0, 3) != 0) send_request(CMD_CLAIM, s, DUR_W'($urandom()));
      send_request(CMD_START, s,
                   ($urandom_range(0, 3) != 0) ? shared_dur : pick_duration());
    end
    repeat ($urandom_range(1, 8)) begin
      send_request(CMD_TICK, any_slot(), DUR_W'($urandom()));
      if ($urandom_range(0, 2) == 0) send_request(CMD_QUERY, any_slot(), DUR_W'($urandom()));
    end
    for (int i = 0; i < n_slots; i++) begin
      if ($urandom_range(0, 2) == 0)
        send_request(CMD_RELEASE, slot_field_t'((base + i) % NUM_SLOTS), DUR_W'($urandom()));
    end
  endtask

  // noise: any code, any slot, any duration, including unknown commands
  task automatic run_noise();
    repeat ($urandom_range(1, 4))
      send_request(CMD_W'($urandom_range(0, int'(CMD_LAST_CODE))), any_slot(),
                   DUR_W'($urandom()));
  endtask

  // back-pressure on results: free runs broken by stalls of random length
  initial begin
    out_stall_i = 1'b0;
    forever begin
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      if (!calm) begin
        repeat (pick_idle_len()) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int random_start;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    calm       = 1'b0;
    sent       = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    // tick on an empty bank: no result at all
    send_request(CMD_TICK, 4'd0, 32'd0);
    // claim, then a second claim on the same slot is refused
    send_request(CMD_CLAIM, 4'd0, 32'hFFFF_FFFF);
    send_request(CMD_CLAIM, 4'd0, 32'd0);
    // arming an unclaimed slot is refused, stopping it is always fine
    send_request(CMD_START, 4'd15, 32'd5);
    send_request(CMD_START, 4'd15, 32'd0);
    // largest count, read back, then a restart with a short count
    send_request(CMD_START, 4'd0, DUR_W'(COUNT_MAX));
    send_request(CMD_QUERY, 4'd0, 32'd0);
    send_request(CMD_START, 4'd0, 32'd2);
    send_request(CMD_QUERY, 4'd0, 32'hFFFF_FFFF);
    send_request(CMD_TICK, 4'd15, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 4'd0, 32'd0);
    // slot 0 runs out here and goes idle
    send_request(CMD_TICK, 4'd0, 32'd0);
    send_request(CMD_QUERY, 4'd0, 32'd0);
    // release cancels a running timer without an expiry
    send_request(CMD_CLAIM, 4'd15, 32'd0);
    send_request(CMD_START, 4'd15, 32'd3);
    send_request(CMD_RELEASE, 4'd15, 32'd0);
    send_request(CMD_TICK, 4'd0, 32'd0);
    send_request(CMD_RELEASE, 4'd15, 32'd0);
    // unknown command codes
    send_request(CMD_FIRST_UNUSED, 4'd9, 32'hA5A5_5A5A);
    send_request(CMD_LAST_CODE, 4'd6, 32'd1);
    // query of a slot that was released and is no longer claimed
    send_request(CMD_QUERY, 4'd15, 32'd7);
    // two slots expiring on one tick, last flag on the higher slot only
    send_request(CMD_START, 4'd0, 32'd1);
    send_request(CMD_CLAIM, 4'd5, 32'd0);
    send_request(CMD_START, 4'd5, 32'd1);
    send_request(CMD_TICK, 4'd3, 32'd0);

    // random part: mostly well-formed bursts, some noise, some calm stretches
    random_start = sent;
    while (sent - random_start < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 4) == 0) run_noise();
      else run_timer_burst();
    end

    in_valid_i <= 1'b0;
    calm = 1'b1;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
